/* design/nrmc_pkg.sv */
// Package: beat types, parse codes and character constants for the RMC field parser.
`timescale 1ns / 1ps

package nrmc_pkg;

  localparam int NUM_FIELDS        = 9;
  localparam int MAX_FIELD_DEFAULT = 20;

  localparam logic [2:0] HEADER_LEN = 3'd7;

  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef enum logic [1:0] {
    ST_BUSY = 2'd0,
    ST_OK   = 2'd1,
    ST_FAIL = 2'd2,
    ST_READ = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_HEADER = 2'd1,
    PH_FIELDS = 2'd2,
    PH_DONE   = 2'd3
  } phase_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
    logic [3:0] read_field;
    logic [4:0] read_pos;
  } in_beat_t;

  typedef struct packed {
    status_e    status;
    logic       field_done;
    logic [3:0] field_index;
    logic [4:0] field_length;
    logic       field_kept;
    logic [7:0] read_char;
  } out_beat_t;

endpackage

/* design/nmea_rmc_field_parser_unit.sv */
// RMC sentence field parser: header skip, field split, record store and record read-back.
//
// Input channel (in_valid_i / in_ready_o / in_data_i) carries one beat per sentence byte or
// per record read. Output channel (out_valid_o / out_ready_i / out_data_o) returns exactly
// one beat for every input beat, in order.
// Results are registered: a beat accepted at a clock edge shows its result after that edge.
// Throughput is one beat per cycle while out_ready_i keeps the output moving; parse state,
// record lengths and bank selects update at the accept edge, and the single record memory
// takes one write (sentence byte) or one registered read (record read) per cycle.
// Each record has two banks in the memory. Characters of the open field go to the bank
// not currently shown; closing a kept field flips that record's bank and sets its length,
// so an abandoned or dropped field never disturbs the stored record.
// Reset clears the parse state, all record lengths and bank selects; the memory itself is
// not cleared since no character is visible before its record length covers it.
// When the receiver stalls, the result stays in the output register and in_ready_o drops
// until the result is taken; with out_ready_i high a new beat enters every cycle.
`timescale 1ns / 1ps

module nmea_rmc_field_parser_unit
  import nrmc_pkg::*;
#(
  parameter int MAX_FIELD = MAX_FIELD_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_data_o
);

  localparam int CW    = $clog2(MAX_FIELD);
  localparam int DEPTH = 2 * NUM_FIELDS * MAX_FIELD;
  localparam int AW    = $clog2(DEPTH);

  // parse state
  phase_e                  phase_q, phase_d;
  logic [2:0]              hdr_cnt_q, hdr_cnt_d;
  logic [3:0]              fld_num_q, fld_num_d;
  logic [CW-1:0]           chr_cnt_q, chr_cnt_d;
  logic [CW-1:0]           len_q [NUM_FIELDS];
  logic [CW-1:0]           len_d [NUM_FIELDS];
  logic [NUM_FIELDS-1:0]   bank_q, bank_d;

  // working copies after a possible restart
  phase_e                  ph_w;
  logic [2:0]              hdr_w;
  logic [2:0]              hdr_inc;
  logic [3:0]              fld_w;
  logic [3:0]              fld_inc;
  logic [CW-1:0]           chr_w;
  logic [CW-1:0]           keep_len;
  logic                    kept;
  logic                    is_delim;

  logic                    in_accept;
  out_beat_t               res_d, res_q;
  logic                    out_valid_q;

  logic [7:0]              mem [DEPTH];
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  logic                    rd_en;
  logic [AW-1:0]           rd_addr;
  logic [7:0]              rd_data_q;
  logic                    chr_ok_q;
  logic [4:0]              wr_row;
  logic [4:0]              rd_row;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_accept  = in_valid_i && in_ready_o;
  assign is_delim   = (in_data_i.data_byte == CH_COMMA) || (in_data_i.data_byte == CH_STAR);

  always_comb begin
    phase_d   = phase_q;
    hdr_cnt_d = hdr_cnt_q;
    fld_num_d = fld_num_q;
    chr_cnt_d = chr_cnt_q;
    len_d     = len_q;
    bank_d    = bank_q;
    res_d     = '0;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    ph_w      = in_data_i.first_byte ? PH_HEADER : phase_q;
    hdr_w     = in_data_i.first_byte ? 3'd0 : hdr_cnt_q;
    fld_w     = in_data_i.first_byte ? 4'd0 : fld_num_q;
    chr_w     = in_data_i.first_byte ? '0 : chr_cnt_q;
    hdr_inc   = hdr_w + 3'd1;
    fld_inc   = fld_w + 4'd1;
    kept      = !(((fld_w == 4'd2) || (fld_w == 4'd4)) && (chr_w < CW'(2)));
    keep_len  = chr_w;
    if ((fld_w == 4'd1) || (fld_w == 4'd3) || (fld_w == 4'd5)) begin
      keep_len = (chr_w != '0) ? CW'(1) : '0;
    end
    wr_row    = {fld_w, ~bank_q[fld_w]};
    rd_row    = {in_data_i.read_field, bank_q[in_data_i.read_field]};
    wr_addr   = AW'(wr_row) * AW'(MAX_FIELD) + AW'(chr_w);
    rd_addr   = AW'(rd_row) * AW'(MAX_FIELD) + AW'(in_data_i.read_pos);

    if (in_accept) begin
      if (in_data_i.kind == KIND_READ) begin
        res_d.status      = ST_READ;
        res_d.field_index = in_data_i.read_field;
        if (in_data_i.read_field < 4'(NUM_FIELDS)) begin
          res_d.field_length = 5'(len_q[in_data_i.read_field]);
          rd_en = 5'(in_data_i.read_pos) < 5'(len_q[in_data_i.read_field]);
        end
      end else begin
        phase_d   = ph_w;
        hdr_cnt_d = hdr_w;
        fld_num_d = fld_w;
        chr_cnt_d = chr_w;
        case (ph_w)
          PH_HEADER: begin
            hdr_cnt_d = hdr_inc;
            if (hdr_inc >= HEADER_LEN) begin
              phase_d = PH_FIELDS;
            end
            if (in_data_i.last_byte) begin
              res_d.status = ST_OK;
              phase_d      = PH_DONE;
            end
          end
          PH_FIELDS: begin
            if ((chr_w == '0) && ((in_data_i.data_byte == CH_STAR) ||
                                  (in_data_i.data_byte == CH_DOLLAR))) begin
              res_d.status = ST_FAIL;
              phase_d      = PH_DONE;
            end else if (is_delim) begin
              if (kept) begin
                len_d[fld_w]  = keep_len;
                bank_d[fld_w] = ~bank_q[fld_w];
              end
              res_d.field_done   = 1'b1;
              res_d.field_index  = fld_w;
              res_d.field_length = 5'(chr_w);
              res_d.field_kept   = kept;
              fld_num_d          = fld_inc;
              chr_cnt_d          = '0;
              if ((fld_inc >= 4'(NUM_FIELDS)) || in_data_i.last_byte) begin
                res_d.status = ST_OK;
                phase_d      = PH_DONE;
              end
            end else if (chr_w >= CW'(MAX_FIELD - 1)) begin
              res_d.status = ST_FAIL;
              phase_d      = PH_DONE;
            end else begin
              wr_en     = 1'b1;
              chr_cnt_d = chr_w + CW'(1);
              if (in_data_i.last_byte) begin
                res_d.status = ST_FAIL;
                phase_d      = PH_DONE;
              end
            end
          end
          default: begin
            // idle or done: byte ignored
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      hdr_cnt_q   <= '0;
      fld_num_q   <= '0;
      chr_cnt_q   <= '0;
      bank_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_FIELDS; i++) begin
        len_q[i] <= '0;
      end
    end else begin
      phase_q   <= phase_d;
      hdr_cnt_q <= hdr_cnt_d;
      fld_num_q <= fld_num_d;
      chr_cnt_q <= chr_cnt_d;
      bank_q    <= bank_d;
      len_q     <= len_d;
      if (in_accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      res_q    <= res_d;
      chr_ok_q <= rd_en;
    end
  end

  // record memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= in_data_i.data_byte;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_comb begin
    out_data_o           = res_q;
    out_data_o.read_char = chr_ok_q ? rd_data_q : 8'd0;
  end

  assign out_valid_o = out_valid_q;

  a_chr_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chr_cnt_q <= CW'(MAX_FIELD - 1))
    else $error("open field character count beyond field capacity");

  a_fld_num_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_FIELDS) |-> (fld_num_q < 4'(NUM_FIELDS)))
    else $error("field number out of range while parsing fields");

  a_read_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (in_data_i.kind == KIND_READ)) |=>
      (out_valid_q && (res_q.status == ST_READ) && !res_q.field_done))
    else $error("read beat did not produce a read reply");

  a_outcome_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && ((res_d.status == ST_OK) || (res_d.status == ST_FAIL))) |=>
      (phase_q == PH_DONE))
    else $error("sentence outcome reported without entering done phase");

  a_kept_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.field_kept) |-> res_q.field_done)
    else $error("field kept flagged without a closed field");

endmodule

/* sim/tb_nmea_rmc_field_parser_unit.sv */
// Testbench for the RMC field parser: sentence and record-read beats checked against an in-bench model.
`timescale 1ns / 1ps

module tb_nmea_rmc_field_parser_unit;
  import nrmc_pkg::*;

  localparam int FIELD_MAX    = MAX_FIELD_DEFAULT;
  localparam int IDLE_LIMIT   = 3000;
  localparam int STALL_CYCLES = 300;

  typedef enum int {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PERIODIC
  } rx_mode_e;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_beat_t out_data;

  nmea_rmc_field_parser_unit #(
    .MAX_FIELD(FIELD_MAX)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  // parser model state
  logic [7:0] rec_char   [NUM_FIELDS][FIELD_MAX];
  logic [4:0] rec_len    [NUM_FIELDS];
  logic [7:0] open_chars [FIELD_MAX];
  logic [2:0] hdr_seen;
  logic [3:0] fld_no;
  logic [4:0] chr_no;
  phase_e     phase;

  out_beat_t  predicted[$];
  logic [7:0] line_q[$];

  int       errors     = 0;
  int       beats_in   = 0;
  int       ok_cnt     = 0;
  int       fail_cnt   = 0;
  int       read_cnt   = 0;
  int       burst_left = 0;
  bit       tx_gaps_on = 1'b1;
  int       hold_len   = 0;
  rx_mode_e rx_mode    = RX_RANDOM;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic out_beat_t parse_beat(in_beat_t b);
    out_beat_t r;
    int        f;
    int        n;
    int        keep;
    bit        kept;
    r = '0;
    if (b.kind == KIND_READ) begin
      r.status      = ST_READ;
      r.field_index = b.read_field;
      if (b.read_field < 4'(NUM_FIELDS)) begin
        r.field_length = rec_len[b.read_field];
        if (b.read_pos < rec_len[b.read_field]) begin
          r.read_char = rec_char[b.read_field][b.read_pos];
        end
      end
      return r;
    end
    if (b.first_byte) begin
      phase    = PH_HEADER;
      hdr_seen = '0;
      fld_no   = '0;
      chr_no   = '0;
    end
    case (phase)
      PH_HEADER: begin
        hdr_seen = hdr_seen + 3'd1;
        if (hdr_seen >= HEADER_LEN) phase = PH_FIELDS;
        if (b.last_byte) begin
          phase    = PH_DONE;
          r.status = ST_OK;
        end
      end
      PH_FIELDS: begin
        if (chr_no == '0 && (b.data_byte == CH_STAR || b.data_byte == CH_DOLLAR)) begin
          phase    = PH_DONE;
          r.status = ST_FAIL;
        end else if (b.data_byte == CH_COMMA || b.data_byte == CH_STAR) begin
          f    = int'(fld_no);
          n    = int'(chr_no);
          keep = n;
          kept = 1'b1;
          // status/hemisphere keep one char; lat/lon need two chars to be stored
          if (f == 1 || f == 3 || f == 5) keep = (n > 0) ? 1 : 0;
          else if ((f == 2 || f == 4) && n < 2) kept = 1'b0;
          if (kept) begin
            for (int i = 0; i < keep; i++) rec_char[f][i] = open_chars[i];
            rec_len[f] = 5'(keep);
          end
          r.field_done   = 1'b1;
          r.field_index  = 4'(f);
          r.field_length = 5'(n);
          r.field_kept   = kept;
          fld_no         = fld_no + 4'd1;
          chr_no         = '0;
          if (fld_no >= 4'(NUM_FIELDS) || b.last_byte) begin
            phase    = PH_DONE;
            r.status = ST_OK;
          end
        end else if (chr_no >= 5'(FIELD_MAX - 1)) begin
          phase    = PH_DONE;
          r.status = ST_FAIL;
        end else begin
          open_chars[chr_no] = b.data_byte;
          chr_no             = chr_no + 5'd1;
          if (b.last_byte) begin
            phase    = PH_DONE;
            r.status = ST_FAIL;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic field_error(string what, logic [7:0] want, logic [7:0] got);
    $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
    errors++;
  endtask

  task automatic check_result(out_beat_t want, out_beat_t got);
    if (got.status !== want.status)
      field_error("status", 8'(want.status), 8'(got.status));
    if (got.field_done !== want.field_done)
      field_error("field_done", 8'(want.field_done), 8'(got.field_done));
    if (got.field_index !== want.field_index)
      field_error("field_index", 8'(want.field_index), 8'(got.field_index));
    if (got.field_length !== want.field_length)
      field_error("field_length", 8'(want.field_length), 8'(got.field_length));
    if (got.field_kept !== want.field_kept)
      field_error("field_kept", 8'(want.field_kept), 8'(got.field_kept));
    if (got.read_char !== want.read_char)
      field_error("read_char", want.read_char, got.read_char);
  endtask

  always @(posedge clk) begin : scoreboard
    out_beat_t want;
    if (out_valid === 1'b1 && out_ready) begin
      if (predicted.size() == 0) begin
        $display("%0t: result beat with nothing pending, expected none, actual %h",
                 $time, out_data);
        errors++;
      end else begin
        want = predicted.pop_front();
        check_result(want, out_data);
      end
    end
    if (in_valid && in_ready === 1'b1) begin
      want = parse_beat(in_data);
      predicted.push_back(want);
      beats_in++;
      case (want.status)
        ST_OK:   ok_cnt++;
        ST_FAIL: fail_cnt++;
        ST_READ: read_cnt++;
        default: ;
      endcase
    end
  end

  initial begin : receiver
    int rx_tick;
    rx_tick = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      rx_tick++;
      if (hold_len > 0) begin
        // long hold-off: output register fills and input side must stall
        out_ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end else begin
        case (rx_mode)
          RX_ALWAYS: out_ready <= 1'b1;
          RX_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
          default:   out_ready <= (rx_tick % 11) >= 3;
        endcase
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no beat moved for %0d cycles", $time, quiet);
    $display("tb_nmea_rmc_field_parser_unit: FAIL");
    $finish;
  end

  task automatic send_beat(in_beat_t b);
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_ready !== 1'b1);
    if (tx_gaps_on) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 15);
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  task automatic push_byte(logic [7:0] d, bit is_first, bit is_last);
    in_beat_t b;
    b.kind       = KIND_BYTE;
    b.data_byte  = d;
    b.first_byte = is_first;
    b.last_byte  = is_last;
    b.read_field = 4'($urandom_range(0, 15));
    b.read_pos   = 5'($urandom_range(0, 31));
    send_beat(b);
  endtask

  task automatic read_record(logic [3:0] f, logic [4:0] p);
    in_beat_t b;
    b.kind       = KIND_READ;
    b.data_byte  = 8'($urandom_range(0, 255));
    b.first_byte = 1'($urandom_range(0, 1));
    b.last_byte  = 1'($urandom_range(0, 1));
    b.read_field = f;
    b.read_pos   = p;
    send_beat(b);
  endtask

  task automatic read_random();
    logic [3:0] f;
    logic [4:0] p;
    f = 4'(($urandom_range(0, 7) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8));
    p = 5'(($urandom_range(0, 7) == 0) ? $urandom_range(20, 31) : $urandom_range(0, 19));
    read_record(f, p);
  endtask

  task automatic noise_beat();
    in_beat_t b;
    b.kind       = ($urandom_range(0, 3) == 0) ? KIND_READ : KIND_BYTE;
    b.data_byte  = 8'($urandom_range(0, 255));
    b.first_byte = ($urandom_range(0, 5) == 0);
    b.last_byte  = ($urandom_range(0, 5) == 0);
    b.read_field = 4'($urandom_range(0, 15));
    b.read_pos   = 5'($urandom_range(0, 31));
    send_beat(b);
  endtask

  task automatic send_line(bit mark_last, int read_pct);
    for (int i = 0; i < line_q.size(); i++) begin
      if ($urandom_range(0, 99) < read_pct) read_random();
      push_byte(line_q[i], i == 0, mark_last && i == line_q.size() - 1);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    // let the last accepted beat reach the predicted queue first
    @(posedge clk);
    while (predicted.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endfunction

  function automatic logic [7:0] rand_char(bit at_start);
    logic [7:0] c;
    if ($urandom_range(0, 3) != 0) begin
      c = 8'h30 + 8'($urandom_range(0, 9));
    end else begin
      do c = 8'($urandom_range(0, 255));
      while (c == CH_COMMA || c == CH_STAR || (at_start && c == CH_DOLLAR));
    end
    return c;
  endfunction

  function automatic int field_len(int f);
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, FIELD_MAX - 1);
    case (f)
      0:       return $urandom_range(0, 1) ? 6 : 10;
      1, 3, 5: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : 1;
      2, 4:    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : 8 + f / 2;
      8:       return 6;
      default: return $urandom_range(0, 6);
    endcase
  endfunction

  // bad_at: field that starts with '$' or '*'; long_at: field pushed near/over the limit
  function automatic void build_rmc(int bad_at, int long_at);
    string hex_digits;
    int    n;
    bit    star_end;
    hex_digits = "0123456789ABCDEF";
    line_q.delete();
    case ($urandom_range(0, 3))
      0:       repeat (7) line_q.push_back(8'($urandom_range(0, 255)));
      1:       add_str("$GNRMC,");
      default: add_str("$GPRMC,");
    endcase
    star_end = $urandom_range(0, 1);
    for (int f = 0; f < NUM_FIELDS; f++) begin
      n = (f == long_at) ? $urandom_range(FIELD_MAX - 2, FIELD_MAX + 2) : field_len(f);
      if (f == bad_at) line_q.push_back($urandom_range(0, 1) ? CH_STAR : CH_DOLLAR);
      for (int i = 0; i < n; i++) line_q.push_back(rand_char(i == 0 && f != bad_at));
      line_q.push_back((f == NUM_FIELDS - 1 && star_end) ? CH_STAR : CH_COMMA);
    end
    if (star_end) begin
      line_q.push_back(hex_digits[$urandom_range(0, 15)]);
      line_q.push_back(hex_digits[$urandom_range(0, 15)]);
      line_q.push_back(8'h0D);
      line_q.push_back(8'h0A);
    end else begin
      add_str("003.1,W*6A");
    end
  endfunction

  task automatic test_directed();
    read_record(4'd15, 5'd31);
    read_record(4'd0, 5'd0);
    push_byte("1", 1'b0, 1'b0);
    line_q.delete();
    add_str("$GP");
    send_line(1'b1, 0);
    // fields 0 and 1 stored, short latitude dropped, then a field opening with '*'
    line_q.delete();
    add_str("$GPRMC,");
    line_q.push_back(8'hFF);
    line_q.push_back(8'h00);
    add_str(",AB,5,*");
    send_line(1'b0, 0);
    push_byte("9", 1'b0, 1'b1);
    read_record(4'd0, 5'd1);
    read_record(4'd1, 5'd0);
    read_record(4'd1, 5'd1);
    read_record(4'd2, 5'd0);
    drain();
  endtask

  task automatic test_well_formed();
    tx_gaps_on = 1'b1;
    repeat (12) begin
      rx_mode = $urandom_range(0, 1) ? RX_RANDOM : RX_PERIODIC;
      build_rmc(-1, -1);
      send_line(1'b1, 8);
    end
    drain();
  endtask

  task automatic test_back_to_back();
    tx_gaps_on = 1'b0;
    rx_mode    = RX_ALWAYS;
    repeat (2) begin
      build_rmc(-1, -1);
      send_line(1'b1, 15);
    end
    drain();
    tx_gaps_on = 1'b1;
  endtask

  task automatic test_broken();
    int cut;
    rx_mode = RX_RANDOM;
    repeat (10) begin
      case ($urandom_range(0, 4))
        0: begin
          build_rmc(-1, -1);
          cut = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 9)
                                            : $urandom_range(1, line_q.size());
          while (line_q.size() > cut) void'(line_q.pop_back());
          send_line(1'b1, 5);
        end
        1: begin
          build_rmc($urandom_range(0, NUM_FIELDS - 1), -1);
          send_line(1'b1, 5);
        end
        2: begin
          build_rmc(-1, $urandom_range(0, NUM_FIELDS - 1));
          send_line(1'b1, 5);
        end
        3: begin
          // no last flag: the next first_byte restarts the parse
          build_rmc(-1, -1);
          send_line(1'b0, 5);
        end
        default: repeat (20) noise_beat();
      endcase
    end
    drain();
  endtask

  task automatic test_back_pressure();
    tx_gaps_on = 1'b0;
    rx_mode    = RX_ALWAYS;
    hold_len   = STALL_CYCLES;
    build_rmc(-1, -1);
    send_line(1'b1, 10);
    build_rmc(-1, -1);
    send_line(1'b1, 10);
    drain();
    tx_gaps_on = 1'b1;
  endtask

  task automatic test_record_sweep();
    rx_mode = RX_PERIODIC;
    for (int f = 0; f < 16; f++) begin
      read_record(4'(f), 5'd0);
      read_record(4'(f), 5'($urandom_range(1, FIELD_MAX - 2)));
      read_record(4'(f), 5'(FIELD_MAX - 1));
      read_record(4'(f), 5'($urandom_range(FIELD_MAX, 31)));
    end
    drain();
  endtask

  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    for (int f = 0; f < NUM_FIELDS; f++) begin
      rec_len[f] = '0;
      for (int i = 0; i < FIELD_MAX; i++) rec_char[f][i] = '0;
    end
    for (int i = 0; i < FIELD_MAX; i++) open_chars[i] = '0;
    hdr_seen = '0;
    fld_no   = '0;
    chr_no   = '0;
    phase    = PH_IDLE;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_well_formed();
    test_back_to_back();
    test_broken();
    test_back_pressure();
    test_record_sweep();

    if (predicted.size() != 0) begin
      $display("%0t: result beats left pending, expected 0 actual %0d",
               $time, predicted.size());
      errors++;
    end

    $display("run covered %0d beats: %0d sentences passed, %0d failed, %0d record reads",
             beats_in, ok_cnt, fail_cnt, read_cnt);
    $display("short, bad-start, over-length, truncated, unterminated and noise sentences; %0d errors",
             errors);
    if (errors == 0) begin
      $display("tb_nmea_rmc_field_parser_unit: PASS");
    end else begin
      $display("tb_nmea_rmc_field_parser_unit: FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/nrmc_pkg.sv
design/nmea_rmc_field_parser_unit.sv
sim/tb_nmea_rmc_field_parser_unit.sv
